>>> sv/mzr_pkg.sv
// Package for the move-to-front zero-run coder.
// Holds field widths, limits, the controller state type and the cell broadcast struct.
// No dependencies.
package mzr_pkg;

  localparam int unsigned TABLE_SIZE_DEF   = 256;
  localparam int unsigned MAX_PREFIX_LIMIT = 16;

  localparam int unsigned CLUSTER_W = 8;
  localparam int unsigned PREFIX_W  = 5;
  localparam int unsigned SYMBOL_W  = 9;
  localparam int unsigned EXTRA_W   = 16;
  localparam int unsigned RUN_W     = 17;
  localparam int unsigned LOG_W     = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CALC,
    ST_EMIT
  } mzr_state_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [CLUSTER_W-1:0] key;
    logic                 restore;
  } mzr_bcast_t;

  // Position of the highest set bit; 0 for an input of 0 or 1.
  function automatic logic [LOG_W-1:0] floor_log2(input logic [RUN_W-1:0] x);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 0; i < RUN_W; i++) begin
      if (x[i]) begin
        r = LOG_W'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> sv/mzr_in_if.sv
// Input channel of the coder: one context-map entry per transaction.
// Depends on mzr_pkg.
interface mzr_in_if;
  logic                           valid;
  logic                           ready;
  logic [mzr_pkg::CLUSTER_W-1:0]  cluster_index;
  logic                           last_entry;

  modport source (output valid, cluster_index, last_entry, input ready);
  modport sink   (input valid, cluster_index, last_entry, output ready);
endinterface

>>> sv/mzr_out_if.sv
// Output channel of the coder: one coded symbol per transaction.
// Depends on mzr_pkg.
interface mzr_out_if;
  logic                          valid;
  logic                          ready;
  logic [mzr_pkg::SYMBOL_W-1:0]  symbol;
  logic [mzr_pkg::EXTRA_W-1:0]   extra_value;
  logic                          last_of_map;

  modport source (output valid, symbol, extra_value, last_of_map, input ready);
  modport sink   (input valid, symbol, extra_value, last_of_map, output ready);
endinterface

>>> sv/mzr_cfg_if.sv
// Configuration write channel: carries the max_run_prefix register value.
// Depends on mzr_pkg.
interface mzr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mzr_pkg::PREFIX_W-1:0]  max_run_prefix;

  modport source (output valid, max_run_prefix, input ready);
  modport sink   (input valid, max_run_prefix, output ready);
endinterface

>>> sv/mzr_cell.sv
// One slot of the recency table: holds an entry and passes its old entry on.
// Depends on mzr_pkg.
module mzr_cell #(
  parameter int unsigned CELL_ID = 0,
  parameter bit          IS_LAST = 1'b0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mzr_pkg::mzr_bcast_t           bcast_i,
  input  logic                          in_valid_i,
  input  logic [mzr_pkg::CLUSTER_W-1:0] in_data_i,
  output logic                          out_valid_o,
  output logic [mzr_pkg::CLUSTER_W-1:0] out_data_o,
  output logic                          hit_o
);

  logic [mzr_pkg::CLUSTER_W-1:0] val_q;
  logic                          fwd_valid_q;
  logic [mzr_pkg::CLUSTER_W-1:0] fwd_data_q;

  // The walk stops here on a match; the last slot always ends it.
  assign hit_o = in_valid_i && ((val_q == bcast_i.key) || IS_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q       <= mzr_pkg::CLUSTER_W'(CELL_ID);
      fwd_valid_q <= 1'b0;
    end else begin
      if (bcast_i.restore) begin
        val_q <= mzr_pkg::CLUSTER_W'(CELL_ID);
      end else if (in_valid_i) begin
        val_q <= in_data_i;
      end
      fwd_valid_q <= in_valid_i && !hit_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      fwd_data_q <= val_q;
    end
  end

  assign out_valid_o = fwd_valid_q;
  assign out_data_o  = fwd_data_q;

endmodule

>>> sv/mzr_ctrl.sv
// Controller: accepts entries, launches the walk, runs zero-run coding, drives results.
// Depends on mzr_pkg and the three channel interfaces.
module mzr_ctrl #(
  parameter int unsigned TABLE_SIZE = mzr_pkg::TABLE_SIZE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  mzr_in_if.sink                 in_ch,
  mzr_out_if.source              out_ch,
  mzr_cfg_if.sink                cfg_ch,
  input  logic [TABLE_SIZE-1:0]  hit_i,
  output logic                   start_o,
  output mzr_pkg::mzr_bcast_t    bcast_o
);

  localparam int unsigned IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned SW = mzr_pkg::SYMBOL_W;
  localparam int unsigned EW = mzr_pkg::EXTRA_W;
  localparam int unsigned RW = mzr_pkg::RUN_W;
  localparam int unsigned PW = mzr_pkg::PREFIX_W;

  mzr_pkg::mzr_state_e state_q, state_d;

  logic [PW-1:0]                 prefix_q;
  logic [mzr_pkg::CLUSTER_W-1:0] key_q;
  logic                          last_q;
  logic                          start_q;
  logic [IW-1:0]                 cnt_q;
  logic [IW-1:0]                 idx_q;
  logic [RW-1:0]                 run_q;
  logic [RW-1:0]                 count_q;
  logic [1:0]                    slot_n_q;
  logic [SW-1:0]                 slot_sym_q  [2];
  logic [EW-1:0]                 slot_ext_q  [2];
  logic                          slot_last_q [2];
  logic                          out_valid_q;
  logic [SW-1:0]                 out_sym_q;
  logic [EW-1:0]                 out_ext_q;
  logic                          out_last_q;

  logic in_fire, hit_any, out_free, in_rdy, emit_done;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign hit_any  = |hit_i;
  assign out_free = !out_valid_q || out_ch.ready;

  // Zero-run coding of the finished search
  logic [PW-1:0]                p_eff;
  logic [RW:0]                  full_w;
  logic [RW-1:0]                full;
  logic [RW-1:0]                half_w;
  logic [mzr_pkg::LOG_W-1:0]    lz;
  logic                         sat;
  logic [SW-1:0]                run_sym, idx_sym;
  logic [EW-1:0]                run_ext;
  logic [RW-1:0]                run_rem;
  logic [1:0]                   calc_n;
  logic [SW-1:0]                calc_sym  [2];
  logic [EW-1:0]                calc_ext  [2];
  logic                         calc_last [2];
  logic [RW-1:0]                count_calc;

  always_comb begin
    p_eff   = (prefix_q > PW'(mzr_pkg::MAX_PREFIX_LIMIT)) ?
              PW'(mzr_pkg::MAX_PREFIX_LIMIT) : prefix_q;
    full_w  = ((RW+1)'(2) << p_eff) - (RW+1)'(1);
    full    = full_w[RW-1:0];
    half_w  = (RW'(1) << p_eff) - RW'(1);
    lz      = mzr_pkg::floor_log2(run_q);
    sat     = (run_q >= full);
    run_rem = run_q - (RW'(1) << lz);
    run_sym = sat ? SW'(p_eff) : SW'(lz);
    run_ext = sat ? half_w[EW-1:0] : run_rem[EW-1:0];
    idx_sym = SW'(idx_q) + SW'(p_eff);

    calc_n        = 2'd0;
    count_calc    = '0;
    calc_sym[0]   = run_sym;
    calc_ext[0]   = run_ext;
    calc_last[0]  = last_q;
    calc_sym[1]   = idx_sym;
    calc_ext[1]   = '0;
    calc_last[1]  = last_q;
    if (idx_q == '0) begin
      if (sat || last_q) begin
        calc_n = 2'd1;
      end else begin
        count_calc = run_q;
      end
    end else if (count_q != '0) begin
      calc_n       = 2'd2;
      calc_last[0] = 1'b0;
    end else begin
      calc_n       = 2'd1;
      calc_sym[0]  = idx_sym;
      calc_ext[0]  = '0;
    end
  end

  // FSM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mzr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    in_rdy    = 1'b0;
    emit_done = 1'b0;
    case (state_q)
      mzr_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          state_d = mzr_pkg::ST_SEARCH;
        end
      end
      mzr_pkg::ST_SEARCH: begin
        if (hit_any) begin
          state_d = mzr_pkg::ST_CALC;
        end
      end
      mzr_pkg::ST_CALC: begin
        state_d = (calc_n == 2'd0) ? mzr_pkg::ST_IDLE : mzr_pkg::ST_EMIT;
      end
      mzr_pkg::ST_EMIT: begin
        if (out_free && (slot_n_q == 2'd1)) begin
          emit_done = 1'b1;
          state_d   = mzr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mzr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= '0;
      start_q     <= 1'b0;
      cnt_q       <= '0;
      count_q     <= '0;
      slot_n_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        prefix_q <= cfg_ch.max_run_prefix;
      end
      start_q <= in_fire;
      if (in_fire) begin
        cnt_q <= '0;
      end else if ((state_q == mzr_pkg::ST_SEARCH) && !hit_any) begin
        cnt_q <= cnt_q + IW'(1);
      end
      if (state_q == mzr_pkg::ST_CALC) begin
        count_q  <= count_calc;
        slot_n_q <= calc_n;
      end else if ((state_q == mzr_pkg::ST_EMIT) && out_free) begin
        slot_n_q <= slot_n_q - 2'd1;
      end
      if (emit_done && last_q) begin
        count_q <= '0;
      end
      if ((state_q == mzr_pkg::ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q  <= in_ch.cluster_index;
      last_q <= in_ch.last_entry;
    end
    if ((state_q == mzr_pkg::ST_SEARCH) && hit_any) begin
      idx_q <= cnt_q;
      run_q <= (cnt_q == '0) ? (count_q + RW'(1)) : count_q;
    end
    if (state_q == mzr_pkg::ST_CALC) begin
      for (int s = 0; s < 2; s++) begin
        slot_sym_q[s]  <= calc_sym[s];
        slot_ext_q[s]  <= calc_ext[s];
        slot_last_q[s] <= calc_last[s];
      end
    end else if ((state_q == mzr_pkg::ST_EMIT) && out_free) begin
      slot_sym_q[0]  <= slot_sym_q[1];
      slot_ext_q[0]  <= slot_ext_q[1];
      slot_last_q[0] <= slot_last_q[1];
    end
    if ((state_q == mzr_pkg::ST_EMIT) && out_free) begin
      out_sym_q  <= slot_sym_q[0];
      out_ext_q  <= slot_ext_q[0];
      out_last_q <= slot_last_q[0];
    end
  end

  assign in_ch.ready        = in_rdy;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_q;
  assign out_ch.symbol      = out_sym_q;
  assign out_ch.extra_value = out_ext_q;
  assign out_ch.last_of_map = out_last_q;
  assign start_o            = start_q;
  assign bcast_o.key        = key_q;
  assign bcast_o.restore    = emit_done && last_q;

  a_calc_after_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mzr_pkg::ST_CALC) |-> ($past(state_q) == mzr_pkg::ST_SEARCH))
    else $error("calc state entered without a finished walk");

  a_accept_starts_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ((state_q == mzr_pkg::ST_SEARCH) && start_q))
    else $error("accepted entry did not launch a walk");

  a_walk_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mzr_pkg::ST_SEARCH) |-> (cnt_q <= IW'(TABLE_SIZE - 1)))
    else $error("walk ran past the last cell");

endmodule

>>> sv/mtf_zero_run_coder.sv
// Top level of the move-to-front zero-run coder: controller plus a row of table cells.
// Depends on mzr_pkg, the channel interfaces, mzr_cell and mzr_ctrl.
//
// Usage:
//  - in_ch carries one context-map entry per transaction (cluster_index, last_entry).
//    out_ch carries coded symbols (symbol, extra_value, last_of_map); cfg_ch writes
//    max_run_prefix (clamped to 16 internally) and is always ready. Write it only
//    while the block is idle.
//  - The recency table lives in a row of TABLE_SIZE cells. An entry walks the row
//    one cell per cycle, each cell taking its left neighbor's old entry, until it
//    finds its match (or reaches the last cell).
//  - One entry is in flight at a time. An entry occupies the block through the walk,
//    the calculation state and one emit step per result it yields (0 to 2); each
//    emit step waits until the output register is free.
//  - Reset puts the table in identity order, clears the zero count and the prefix.
//    After a last entry, the table and the count return to that state when the last
//    result is loaded into the output register.
//  - A stalled receiver holds the output register; the block then waits with its
//    pending results. The next entry is accepted while the final result still waits.
module mtf_zero_run_coder #(
  parameter int unsigned TABLE_SIZE = mzr_pkg::TABLE_SIZE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mzr_in_if.sink    in_ch,
  mzr_out_if.source out_ch,
  mzr_cfg_if.sink   cfg_ch
);

  mzr_pkg::mzr_bcast_t           bcast;
  logic [TABLE_SIZE:0]           link_valid;
  logic [mzr_pkg::CLUSTER_W-1:0] link_data [TABLE_SIZE+1];
  logic [TABLE_SIZE-1:0]         hit_vec;

  mzr_ctrl #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .hit_i   (hit_vec),
    .start_o (link_valid[0]),
    .bcast_o (bcast)
  );

  // The searched entry itself enters the front cell.
  assign link_data[0] = bcast.key;

  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
    mzr_cell #(
      .CELL_ID (g),
      .IS_LAST (g == TABLE_SIZE - 1)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .bcast_i     (bcast),
      .in_valid_i  (link_valid[g]),
      .in_data_i   (link_data[g]),
      .out_valid_o (link_valid[g+1]),
      .out_data_o  (link_data[g+1]),
      .hit_o       (hit_vec[g])
    );
  end

  // Only one entry walks the row, so at most one link carries data.
  a_single_walker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(link_valid))
    else $error("more than one walk active in the cell row");

endmodule
